[hw/rtl/rlis_pkg.sv]
package rlis_pkg;

  // Fixed field widths
  localparam int unsigned IDX_W    = 64;
  localparam int unsigned TERM_W   = 64;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned TRAIL_W  = 7;

  // Command codes
  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_READ     = 3'd1,
    CMD_TERM     = 3'd2,
    CMD_TRUNCATE = 3'd3,
    CMD_COMPACT  = 3'd4,
    CMD_RESTORE  = 3'd5,
    CMD_LOAD     = 3'd6
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_ILLEGAL   = 2'd3
  } status_t;

endpackage

[hw/rtl/rlis_ring.sv]
module rlis_ring
  import rlis_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned HW    = 32,
  parameter int unsigned SW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SW-1:0]     wr_addr,
  input  logic [TERM_W-1:0] wr_term,
  input  logic              wr_kind,
  input  logic [HW-1:0]     wr_handle,
  input  logic [SW-1:0]     rd_addr_a,
  input  logic [SW-1:0]     rd_addr_b,
  output logic [TERM_W-1:0] rd_term_a,
  output logic              rd_kind_a,
  output logic [HW-1:0]     rd_handle_a,
  output logic [TERM_W-1:0] rd_term_b
);

  logic [TERM_W-1:0] term_mem [DEPTH];
  logic              kind_mem [DEPTH];
  logic [HW-1:0]     handle_mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      term_mem[wr_addr]   <= wr_term;
      kind_mem[wr_addr]   <= wr_kind;
      handle_mem[wr_addr] <= wr_handle;
    end
  end

  // Registered reads: full entry on port a, term only on port b
  always_ff @(posedge clk) begin
    rd_term_a   <= term_mem[rd_addr_a];
    rd_kind_a   <= kind_mem[rd_addr_a];
    rd_handle_a <= handle_mem[rd_addr_a];
    rd_term_b   <= term_mem[rd_addr_b];
  end

endmodule

[hw/rtl/replicated_log_index_store_unit.sv]
// Consensus log store: a ring of DEPTH entries (term, kind, payload handle)
// addressed by a 64-bit base offset, plus the snapshot index and term.
// Input channel: a command transfer happens on a rising edge with start high
// and busy low. busy is registered from each transfer and stays high while the
// command executes, so a new command is not taken while busy is high.
// Result channel: out_valid is high for exactly one cycle, registered after
// the exec and fin stages, carrying status, found fields and the log summary.
// The receiver cannot stall; every command yields exactly one result.
// Steps: the ring is read at the command transfer (two read addresses,
// registered), then the command executes and writes the ring / updates the
// indexes, then the last index/term summary is formed into the result register.
// The ring's single write port plus registered read is why busy holds off a new command.
// Reset (rst_n low, synchronous) empties the log and clears base and
// snapshot state; ring contents are not cleared and are only read once
// written. No result is pending after reset.
module replicated_log_index_store_unit
  import rlis_pkg::*;
#(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_command,
  input  logic [IDX_W-1:0]    in_log_index,
  input  logic [TERM_W-1:0]   in_entry_term,
  input  logic                in_entry_kind,
  input  logic [HANDLE_W-1:0] in_payload_handle,
  input  logic [TRAIL_W-1:0]  in_keep_trailing,
  input  logic [IDX_W-1:0]    in_first_index,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [TERM_W-1:0]   out_found_term,
  output logic                out_found_kind,
  output logic [HANDLE_W-1:0] out_found_handle,
  output logic [IDX_W-1:0]    out_last_log_index,
  output logic [TERM_W-1:0]   out_last_log_term,
  output logic [IDX_W-1:0]    out_snap_index,
  output logic [IDX_W-1:0]    out_base_offset
);

  localparam int unsigned SW  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned HSW = (HANDLE_WIDTH < HANDLE_W) ? HANDLE_WIDTH : HANDLE_W;

  // Ring slot of head + pos, pos below DEPTH for any held entry
  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] head,
                                             input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(pos);
    if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
    if (sum >= (CW+1)'(DEPTH)) sum = '0;
    return sum[SW-1:0];
  endfunction

  // Pipeline control
  logic exec_r, fin_r, out_valid_r;
  logic accept;

  // Log state
  logic [SW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  logic [IDX_W-1:0]  snap_idx_r, snap_idx_nxt;
  logic [TERM_W-1:0] snap_term_r, snap_term_nxt;
  logic [TERM_W-1:0] last_term_r, last_term_nxt;

  // Captured command
  cmd_t               cmd_r;
  logic [IDX_W-1:0]   idx_r;
  logic [TERM_W-1:0]  term_r;
  logic               kind_r;
  logic [HSW-1:0]     handle_r;
  logic [TRAIL_W-1:0] trail_r;
  logic [IDX_W-1:0]   first_r;

  // Execute results held for the summary cycle
  status_t           res_status_r, res_status_nxt;
  logic [TERM_W-1:0] res_term_r, res_term_nxt;
  logic              res_kind_r, res_kind_nxt;
  logic [HSW-1:0]    res_handle_r, res_handle_nxt;

  // Result register
  logic [1:0]          out_status_r;
  logic [TERM_W-1:0]   out_found_term_r;
  logic                out_found_kind_r;
  logic [HANDLE_W-1:0] out_found_handle_r;
  logic [IDX_W-1:0]    out_last_idx_r;
  logic [TERM_W-1:0]   out_last_term_r;
  logic [IDX_W-1:0]    out_snap_idx_r;
  logic [IDX_W-1:0]    out_base_r;

  // Ring ports
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  logic [SW-1:0]     rd_addr_a, rd_addr_b;
  logic [TERM_W-1:0] rd_term_a, rd_term_b;
  logic              rd_kind_a;
  logic [HSW-1:0]    rd_handle_a;

  assign accept = start && !exec_r;
  assign busy   = exec_r;

  // Read addresses from the incoming index: the entry itself and the one before it
  assign rd_addr_a = slot_add(head_r, CW'(in_log_index - base_r - 64'd1));
  assign rd_addr_b = slot_add(head_r, CW'(in_log_index - base_r - 64'd2));

  rlis_ring #(
    .DEPTH (DEPTH),
    .HW    (HSW),
    .SW    (SW)
  ) u_ring (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_term     (term_r),
    .wr_kind     (kind_r),
    .wr_handle   (handle_r),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_term_a   (rd_term_a),
    .rd_kind_a   (rd_kind_a),
    .rd_handle_a (rd_handle_a),
    .rd_term_b   (rd_term_b)
  );

  // Execute: command decode against current state and ring read data
  logic [IDX_W-1:0]  tail_idx;
  logic              held_idx, outside, term_ill;
  logic [TERM_W-1:0] chk_term;
  logic [IDX_W-1:0]  retain, remove;
  logic              held_retain;

  always_comb begin
    tail_idx = base_r + IDX_W'(count_r);
    held_idx = (count_r != '0) && (idx_r > base_r) && (idx_r <= tail_idx);
    outside  = ((idx_r <= base_r) && (idx_r != snap_idx_r)) || (idx_r > tail_idx);

    // Checked term lookup
    term_ill = (idx_r == '0) || (base_r > snap_idx_r);
    chk_term = '0;
    if (!term_ill && !outside) begin
      if (idx_r == snap_idx_r) begin
        if (snap_term_r == '0) term_ill = 1'b1;
        if (held_idx && (rd_term_a != snap_term_r)) term_ill = 1'b1;
        chk_term = snap_term_r;
      end else begin
        chk_term = rd_term_a;
      end
    end
    if (term_ill) chk_term = '0;

    retain      = idx_r - IDX_W'(trail_r);
    remove      = retain - base_r;
    held_retain = (count_r != '0) && (retain > base_r) && (retain <= tail_idx);

    head_nxt       = head_r;
    count_nxt      = count_r;
    base_nxt       = base_r;
    snap_idx_nxt   = snap_idx_r;
    snap_term_nxt  = snap_term_r;
    last_term_nxt  = last_term_r;
    res_status_nxt = ST_OK;
    res_term_nxt   = '0;
    res_kind_nxt   = 1'b0;
    res_handle_nxt = '0;
    wr_en          = 1'b0;
    wr_addr        = slot_add(head_r, count_r);

    case (cmd_r)
      CMD_APPEND: begin
        if (count_r >= CW'(DEPTH)) begin
          res_status_nxt = ST_FULL;
        end else if (tail_idx == '1) begin
          res_status_nxt = ST_ILLEGAL;
        end else begin
          wr_en         = exec_r;
          count_nxt     = count_r + CW'(1);
          last_term_nxt = term_r;
        end
      end
      CMD_READ: begin
        if (!held_idx) begin
          res_status_nxt = ST_NOT_FOUND;
        end else begin
          res_term_nxt   = rd_term_a;
          res_kind_nxt   = rd_kind_a;
          res_handle_nxt = rd_handle_a;
        end
      end
      CMD_TERM: begin
        if (term_ill) res_status_nxt = ST_ILLEGAL;
        else if (chk_term == '0) res_status_nxt = ST_NOT_FOUND;
        else res_term_nxt = chk_term;
      end
      CMD_TRUNCATE: begin
        if (idx_r <= snap_idx_r) begin
          res_status_nxt = ST_ILLEGAL;
        end else if ((count_r != '0) && (idx_r <= tail_idx)) begin
          if (idx_r <= base_r + 64'd1) begin
            count_nxt = '0;
          end else begin
            count_nxt     = CW'(idx_r - base_r - 64'd1);
            last_term_nxt = rd_term_b;
          end
        end
      end
      CMD_COMPACT: begin
        if (term_ill || (chk_term == '0)) begin
          res_status_nxt = ST_ILLEGAL;
        end else begin
          snap_idx_nxt  = idx_r;
          snap_term_nxt = chk_term;
          if ((idx_r > IDX_W'(trail_r)) && held_retain) begin
            if (remove >= IDX_W'(count_r)) begin
              count_nxt = '0;
              base_nxt  = idx_r;
            end else begin
              head_nxt  = slot_add(head_r, CW'(remove));
              count_nxt = count_r - CW'(remove);
              base_nxt  = retain;
            end
          end
        end
      end
      CMD_RESTORE: begin
        count_nxt     = '0;
        head_nxt      = '0;
        snap_idx_nxt  = idx_r;
        snap_term_nxt = term_r;
        base_nxt      = idx_r;
      end
      CMD_LOAD: begin
        if ((count_r != '0) || (first_r == '0) || (first_r - 64'd1 > idx_r) ||
            ((idx_r != '0) && (term_r == '0))) begin
          res_status_nxt = ST_ILLEGAL;
        end else begin
          snap_idx_nxt  = idx_r;
          snap_term_nxt = term_r;
          base_nxt      = first_r - 64'd1;
        end
      end
      default: res_status_nxt = ST_ILLEGAL;
    endcase
  end

  // Summary of the updated log
  logic [IDX_W-1:0]  sum_last_idx;
  logic [TERM_W-1:0] sum_last_term;

  always_comb begin
    sum_last_idx = base_r + IDX_W'(count_r);
    if (sum_last_idx == '0) sum_last_term = '0;
    else if (sum_last_idx == snap_idx_r) sum_last_term = snap_term_r;
    else if (sum_last_idx <= base_r) sum_last_term = '0;
    else sum_last_term = last_term_r;
  end

  // Pipeline control and log state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      base_r      <= '0;
      snap_idx_r  <= '0;
      snap_term_r <= '0;
    end else begin
      exec_r      <= accept;
      fin_r       <= exec_r;
      out_valid_r <= fin_r;
      if (exec_r) begin
        head_r      <= head_nxt;
        count_r     <= count_nxt;
        base_r      <= base_nxt;
        snap_idx_r  <= snap_idx_nxt;
        snap_term_r <= snap_term_nxt;
      end
    end
  end

  // Command capture, execute results, result register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd_t'(in_command);
      idx_r    <= in_log_index;
      term_r   <= in_entry_term;
      kind_r   <= in_entry_kind;
      handle_r <= in_payload_handle[HSW-1:0];
      trail_r  <= in_keep_trailing;
      first_r  <= in_first_index;
    end
    if (exec_r) begin
      last_term_r  <= last_term_nxt;
      res_status_r <= res_status_nxt;
      res_term_r   <= res_term_nxt;
      res_kind_r   <= res_kind_nxt;
      res_handle_r <= res_handle_nxt;
    end
    if (fin_r) begin
      out_status_r       <= res_status_r;
      out_found_term_r   <= res_term_r;
      out_found_kind_r   <= res_kind_r;
      out_found_handle_r <= HANDLE_W'(res_handle_r);
      out_last_idx_r     <= sum_last_idx;
      out_last_term_r    <= sum_last_term;
      out_snap_idx_r     <= snap_idx_r;
      out_base_r         <= base_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_term     = out_found_term_r;
  assign out_found_kind     = out_found_kind_r;
  assign out_found_handle   = out_found_handle_r;
  assign out_last_log_index = out_last_idx_r;
  assign out_last_log_term  = out_last_term_r;
  assign out_snap_index     = out_snap_idx_r;
  assign out_base_offset    = out_base_r;

endmodule
